// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL modules.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, off while reset is high.
`define SKS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define SKS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/sks_pkg.sv
// Package for the Salsa20 keystream block: types, round tables and core functions.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package sks_pkg;

  localparam int ROUNDS        = 20;
  localparam int DOUBLE_ROUNDS = (ROUNDS + 1) / 2;
  localparam int STEPS_PER_DR  = 8;
  localparam int STEPS         = STEPS_PER_DR * DOUBLE_ROUNDS;
  localparam int WORDS_OUT     = 8;

  typedef logic [31:0]       word_t;
  typedef logic [15:0][31:0] state_t;
  typedef logic [3:0][63:0]  key_t;
  typedef logic [3:0]        widx_t;

  typedef enum logic [1:0] {
    LINE_B,
    LINE_C,
    LINE_D,
    LINE_A
  } line_t;

  typedef struct packed {
    logic  row;
    line_t line;
  } step_t;

  typedef enum logic [1:0] {
    REG_KEY_0,
    REG_KEY_1,
    REG_KEY_2,
    REG_KEY_3
  } reg_idx_t;

  typedef struct packed {
    logic [63:0] position_low;
    logic [63:0] position_high;
    logic [63:0] nonce_low;
    logic [63:0] nonce_high;
  } in_t;

  typedef struct packed {
    logic [63:0] keystream_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_t;

  typedef struct packed {
    state_t st;
    in_t    job;
  } cell_t;

  // Quarter-round word positions; first index selects column or row round.
  localparam widx_t QA [2][4] = '{'{4'd0, 4'd5, 4'd10, 4'd15}, '{4'd0, 4'd5, 4'd10, 4'd15}};
  localparam widx_t QB [2][4] = '{'{4'd4, 4'd9, 4'd14, 4'd3}, '{4'd1, 4'd6, 4'd11, 4'd12}};
  localparam widx_t QC [2][4] = '{'{4'd8, 4'd13, 4'd2, 4'd7}, '{4'd2, 4'd7, 4'd8, 4'd13}};
  localparam widx_t QD [2][4] = '{'{4'd12, 4'd1, 4'd6, 4'd11}, '{4'd3, 4'd4, 4'd9, 4'd14}};

  function automatic word_t rol32(word_t v, logic [4:0] n);
    logic [63:0] w;
    w = {v, v} << n;
    return w[63:32];
  endfunction

  function automatic state_t init_state(in_t j, key_t k);
    state_t s;
    s[0]  = j.nonce_low[31:0];
    s[1]  = k[0][31:0];
    s[2]  = k[0][63:32];
    s[3]  = k[1][31:0];
    s[4]  = k[1][63:32];
    s[5]  = j.nonce_low[63:32];
    s[6]  = j.position_low[31:0];
    s[7]  = j.position_low[63:32];
    s[8]  = j.position_high[31:0];
    s[9]  = j.position_high[63:32];
    s[10] = j.nonce_high[31:0];
    s[11] = k[2][31:0];
    s[12] = k[2][63:32];
    s[13] = k[3][31:0];
    s[14] = k[3][63:32];
    s[15] = j.nonce_high[63:32];
    return s;
  endfunction

  // One add-rotate-xor line of all four quarter rounds of a round.
  function automatic state_t step_apply(state_t s, step_t stp);
    state_t     r;
    widx_t      dst;
    widx_t      x;
    widx_t      y;
    logic [4:0] rot;
    r = s;
    for (int q = 0; q < 4; q++) begin
      unique case (stp.line)
        LINE_B: begin
          dst = QB[stp.row][q];
          x   = QA[stp.row][q];
          y   = QD[stp.row][q];
          rot = 5'd7;
        end
        LINE_C: begin
          dst = QC[stp.row][q];
          x   = QB[stp.row][q];
          y   = QA[stp.row][q];
          rot = 5'd9;
        end
        LINE_D: begin
          dst = QD[stp.row][q];
          x   = QC[stp.row][q];
          y   = QB[stp.row][q];
          rot = 5'd13;
        end
        LINE_A: begin
          dst = QA[stp.row][q];
          x   = QD[stp.row][q];
          y   = QC[stp.row][q];
          rot = 5'd18;
        end
      endcase
      r[dst] = s[dst] ^ rol32(s[x] + s[y], rot);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/salsa20_keystream_block_top.sv
// Top level of the Salsa20 keystream block: key registers, intake spacing, round chain.
// Depends on sks_pkg, sks_cell, sks_unload and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// A block is accepted when start is high and busy is low; busy then stays high while the
// gap counter counts down, so that blocks enter no faster than the serializer sends them.
// Each block passes a chain of 8 cells per double round (80 cells at 20 rounds), one
// add-rotate-xor line per cell, and up to 11 blocks are in flight at once. The eight
// 64-bit result words of a block leave on consecutive cycles, each marked by result_valid
// for one cycle, the first one after the block has left the last cell and been loaded into
// the unload buffer; the receiver cannot stall. Write key registers only while no block is in flight.
module salsa20_keystream_block_top import sks_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  in_t         job,
  output logic        result_valid,
  output out_t        result,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  key_t       key;
  logic [2:0] gap;
  logic       accept;
  logic       chain_valid [STEPS+1];
  cell_t      chain       [STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_KEY_0: key[0] <= cfg_data;
        REG_KEY_1: key[1] <= cfg_data;
        REG_KEY_2: key[2] <= cfg_data;
        REG_KEY_3: key[3] <= cfg_data;
      endcase
    end
  end

  assign busy   = (gap != 3'd0);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      gap <= 3'd0;
    end else if (accept) begin
      gap <= 3'(WORDS_OUT - 1);
    end else if (gap != 3'd0) begin
      gap <= gap - 3'd1;
    end
  end

  assign chain_valid[0] = accept;
  assign chain[0].st    = init_state(job, key);
  assign chain[0].job   = job;

  for (genvar g = 0; g < STEPS; g++) begin : g_cell
    localparam step_t STP = '{row: 1'((g / 4) % 2), line: line_t'(2'(g % 4))};
    sks_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .step      (STP),
      .src_valid (chain_valid[g]),
      .src       (chain[g]),
      .dst_valid (chain_valid[g+1]),
      .dst       (chain[g+1])
    );
  end

  sks_unload u_unload (
    .clk          (clk),
    .rst          (rst),
    .load         (chain_valid[STEPS]),
    .data         (chain[STEPS]),
    .key          (key),
    .result_valid (result_valid),
    .result       (result)
  );

  `SKS_ASSERT(a_gap_after_accept, clk, rst, accept |=> busy, "accept did not raise busy")

endmodule

`default_nettype wire

// File: rtl/sks_cell.sv
// One cell of the round chain: applies one add-rotate-xor line and registers the state.
// Depends on sks_pkg.
`default_nettype none

module sks_cell import sks_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  step_t step,
  input  logic  src_valid,
  input  cell_t src,
  output logic  dst_valid,
  output cell_t dst
);

  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else begin
      dst_valid <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    dst.st  <= step_apply(src.st, step);
    dst.job <= src.job;
  end

endmodule

`default_nettype wire

// File: rtl/sks_unload.sv
// Feed-forward add and result serializer: one 64-bit keystream word per cycle.
// Depends on sks_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module sks_unload import sks_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  load,
  input  cell_t data,
  input  key_t  key,
  output logic  result_valid,
  output out_t  result
);

  localparam logic [2:0] LAST_IDX = 3'(WORDS_OUT - 1);

  state_t     init;
  state_t     sum;
  state_t     sbuf;
  logic       active;
  logic [2:0] idx;

  always_comb begin
    init = init_state(data.job, key);
    for (int k = 0; k < 16; k++) begin
      sum[k] = data.st[k] + init[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      idx    <= 3'd0;
    end else if (load) begin
      active <= 1'b1;
      idx    <= 3'd0;
    end else if (active) begin
      idx <= idx + 3'd1;
      if (idx == LAST_IDX) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sbuf <= sum;
    end else if (active) begin
      sbuf <= sbuf >> 64;
    end
  end

  assign result_valid          = active;
  assign result.keystream_word = {sbuf[1], sbuf[0]};
  assign result.word_index     = idx;
  assign result.last_word      = (idx == LAST_IDX);

  `SKS_ASSERT(a_load_free, clk, rst, load |-> (!active || idx == LAST_IDX), "block arrived mid-transfer")
  `SKS_ASSERT(a_stop_last, clk, rst, (active && idx == LAST_IDX && !load) |=> !active, "extra word")

endmodule

`default_nettype wire
